// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SOKC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SOKC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sokc_pkg.sv =====
// ----------------------------------------------------------------------------
// sokc_pkg
// Widths, command codes and defaults of the sorted key occurrence counter.
// ----------------------------------------------------------------------------
package sokc_pkg;

  localparam int SOKC_DEPTH_DEF = 1024;

  localparam int CMD_W       = 2;
  localparam int VALUE_W     = 32;
  localparam int IDX_OUT_W   = 10;
  localparam int OCC_W       = 11;
  localparam int RES_W       = 1 + OCC_W + IDX_OUT_W + IDX_OUT_W + 1;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef logic [RES_W-1:0] res_t;

endpackage

// ===== sv/sorted_key_occurrence_count_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_occurrence_count_top
// Sorted element store with first/last occurrence search and count.
//
// Input channel (in_*): in_tuser carries the command (clear, append, query),
// in_tdata the signed 32-bit value. An item is taken when in_tvalid and
// in_tready are high; in_tready is high only while the sequencer is idle.
// Result channel (out_*): one result item per input item, registered, held
// until out_tready. A new item is accepted while a result still waits.
// Clear, append, an unused command and a query on an empty store pass from
// accept through the push state into the output register. A query runs binary
// searches on one shared compare unit over the store: each probe reads one
// entry, plus a read of the neighbor entry whenever a probe hits the key. A
// missed key ends after the first search; a found key runs both. The next item
// is taken the cycle after the result register loads.
// Reset clears the length and all control state; store contents are not
// cleared and are only read below the current length.
// A stalled receiver holds the result; the next finished result waits in the
// sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_key_occurrence_count_top #(
  parameter int STORE_DEPTH = sokc_pkg::SOKC_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sokc_pkg::VALUE_W-1:0]     in_tdata,   // [31:0] value
  input  logic [sokc_pkg::CMD_W-1:0]       in_tuser,   // [1:0] command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] found, [11:1] occurrences, [21:12] first_index, [31:22] last_index,
  // [32] overflow, upper bits zero
  output logic [sokc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sokc_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LW = $clog2(STORE_DEPTH + 1);
  localparam int IW = LW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FCMP = 3'd1;
  localparam logic [2:0] S_FNBR = 3'd2;
  localparam logic [2:0] S_LCMP = 3'd3;
  localparam logic [2:0] S_LNBR = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [VALUE_W-1:0] mem [STORE_DEPTH];

  logic [2:0]                state_r, state_nxt;
  logic [LW-1:0]             len_r, len_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic signed [IW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic signed [IW-1:0]      first_r, first_nxt;
  res_t                      res_r, res_nxt;
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;
  logic                      out_load;

  logic signed [VALUE_W-1:0] rd_q;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      mem_we;

  logic                      in_fire;
  logic signed [IW-1:0]      len_m1;
  logic                      step_req, step_last, step_cont;
  logic signed [IW-1:0]      step_lo, step_hi, step_mid;
  logic signed [IW:0]        step_sum;
  logic                      fin_req;
  logic signed [IW-1:0]      fin_last;
  logic signed [IW:0]        occ_diff;
  logic [31:0]               fi_ext, li_ext, occ_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign len_m1    = $signed({1'b0, len_r}) - IW'(1);
  assign mem_we    = in_fire && (in_tuser == CMD_APPEND) && (len_r < LW'(STORE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    first_nxt = first_r;
    res_nxt   = res_r;
    out_load  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = mid_r[AW-1:0];
    step_req  = 1'b0;
    step_last = 1'b0;
    step_lo   = lo_r;
    step_hi   = hi_r;
    fin_req   = 1'b0;
    fin_last  = mid_r;
    step_sum  = '0;
    step_mid  = '0;
    step_cont = 1'b0;
    occ_diff  = '0;
    fi_ext    = '0;
    li_ext    = '0;
    occ_ext   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          state_nxt = S_PUSH;
          case (in_tuser)
            CMD_CLEAR: begin
              len_nxt = '0;
            end
            CMD_APPEND: begin
              if (mem_we) begin
                len_nxt = len_r + LW'(1);
              end else begin
                res_nxt[RES_W-1] = 1'b1;
              end
            end
            CMD_QUERY: begin
              key_nxt  = $signed(in_tdata);
              step_lo  = '0;
              step_hi  = len_m1;
              step_req = 1'b1;
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end
      S_FCMP: begin
        if (rd_q > key_r) begin
          step_hi  = mid_r - IW'(1);
          step_req = 1'b1;
        end else if (rd_q < key_r) begin
          step_lo  = mid_r + IW'(1);
          step_req = 1'b1;
        end else if (mid_r == '0) begin
          first_nxt = mid_r;
          step_lo   = '0;
          step_hi   = len_m1;
          step_last = 1'b1;
          step_req  = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(mid_r - IW'(1));
          state_nxt = S_FNBR;
        end
      end
      S_FNBR: begin
        if (rd_q != key_r) begin
          first_nxt = mid_r;
          step_lo   = '0;
          step_hi   = len_m1;
          step_last = 1'b1;
        end else begin
          step_hi = mid_r - IW'(1);
        end
        step_req = 1'b1;
      end
      S_LCMP: begin
        step_last = 1'b1;
        if (rd_q > key_r) begin
          step_hi  = mid_r - IW'(1);
          step_req = 1'b1;
        end else if (rd_q < key_r) begin
          step_lo  = mid_r + IW'(1);
          step_req = 1'b1;
        end else if (mid_r == len_m1) begin
          fin_req = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(mid_r + IW'(1));
          state_nxt = S_LNBR;
        end
      end
      S_LNBR: begin
        step_last = 1'b1;
        if (rd_q != key_r) begin
          fin_req = 1'b1;
        end else begin
          step_lo  = mid_r + IW'(1);
          step_req = 1'b1;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // shared probe unit: midpoint, loop test and next read
    step_sum  = {step_lo[IW-1], step_lo} + {step_hi[IW-1], step_hi};
    step_mid  = step_sum[IW:1];
    step_cont = (step_lo <= step_hi);
    if (step_req) begin
      if (step_cont) begin
        lo_nxt    = step_lo;
        hi_nxt    = step_hi;
        mid_nxt   = step_mid;
        rd_en     = 1'b1;
        rd_addr   = step_mid[AW-1:0];
        state_nxt = step_last ? S_LCMP : S_FCMP;
      end else if (step_last) begin
        fin_req  = 1'b1;
        fin_last = first_r;
      end else begin
        res_nxt   = '0;
        state_nxt = S_PUSH;
      end
    end

    if (fin_req) begin
      occ_diff = {fin_last[IW-1], fin_last} - {first_r[IW-1], first_r} + (IW+1)'(1);
      fi_ext   = 32'($unsigned(first_r));
      li_ext   = 32'($unsigned(fin_last));
      occ_ext  = (fin_last >= first_r) ? 32'($unsigned(occ_diff)) : '0;
      res_nxt  = {1'b0, li_ext[IDX_OUT_W-1:0], fi_ext[IDX_OUT_W-1:0],
                  occ_ext[OCC_W-1:0], 1'b1};
      state_nxt = S_PUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[len_r[AW-1:0]] <= in_tdata;
    end
    if (rd_en) begin
      rd_q <= $signed(mem[rd_addr]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    first_r <= first_nxt;
    res_r   <= res_nxt;
    if (out_load) begin
      out_data_r <= OUT_TDATA_W'(res_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/sokc_checker.sv =====
// ----------------------------------------------------------------------------
// sokc_checker
// Port-level checks of the sorted key occurrence counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sokc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sokc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sokc_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  `SOKC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready, "ready right after accept")
  `SOKC_ASSERT_IMP(a_no_spurious_out, clk, rst_n, out_tvalid, pend_r != 2'd0, "result without item")
  `SOKC_ASSERT_IMP(a_two_in_flight, clk, rst_n, in_acc, pend_r != 2'd2, "third item accepted")
  `SOKC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind sorted_key_occurrence_count_top sokc_checker u_sokc_checker (.*);

// ===== sim/sorted_key_occurrence_count_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_occurrence_count_top_tb
// Self-checking bench for the sorted key occurrence counter. A queue of
// clear, append, query and unused commands feeds a stream driver with random
// gaps. Each accepted item updates a local copy of the store and predicts the
// found flag, both indices, the count and the overflow flag. A monitor checks
// every result item against the oldest prediction while the receiver stalls
// at random.
// ----------------------------------------------------------------------------
module sorted_key_occurrence_count_top_tb;
  import sokc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DEPTH        = SOKC_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    bit                 sync;
  } command_t;

  typedef struct packed {
    logic                 ovf;
    logic [IDX_OUT_W-1:0] last;
    logic [IDX_OUT_W-1:0] first;
    logic [OCC_W-1:0]     occ;
    logic                 found;
  } count_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [VALUE_W-1:0]     in_tdata   = '0;
  logic [CMD_W-1:0]       in_tuser   = CMD_CLEAR;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic                   in_taken   = 1'b0;

  command_t               command_queue[$];
  count_result_t          expected_counts[$];
  logic signed [31:0]     model_store[DEPTH];
  int                     model_len  = 0;
  int                     mismatches = 0;
  int                     queued_items = 0;
  int                     cycles     = 0;
  int                     send_gap   = 0;
  int                     send_quiet = 0;
  int                     recv_stall = 0;
  int                     recv_quiet = 0;

  sorted_key_occurrence_count_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int lowest_match(input logic signed [31:0] key);
    int lo, hi, mid;
    lo = 0;
    hi = model_len - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (model_store[mid] > key) hi = mid - 1;
      else if (model_store[mid] < key) lo = mid + 1;
      else if (mid == 0 || model_store[mid-1] != key) return mid;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic int highest_match(input logic signed [31:0] key);
    int lo, hi, mid;
    lo = 0;
    hi = model_len - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (model_store[mid] > key) hi = mid - 1;
      else if (model_store[mid] < key) lo = mid + 1;
      else if (mid == model_len - 1 || model_store[mid+1] != key) return mid;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  function automatic count_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [VALUE_W-1:0] value);
    count_result_t res;
    int lo_idx, hi_idx;
    res = '0;
    case (cmd)
      CMD_CLEAR: model_len = 0;
      CMD_APPEND: begin
        if (model_len < DEPTH) begin
          model_store[model_len] = value;
          model_len++;
        end else begin
          res.ovf = 1'b1;
        end
      end
      CMD_QUERY: begin
        lo_idx = lowest_match(value);
        if (lo_idx >= 0) begin
          hi_idx = highest_match(value);
          if (hi_idx < 0) hi_idx = lo_idx;
          res.found = 1'b1;
          res.first = lo_idx[IDX_OUT_W-1:0];
          res.last  = hi_idx[IDX_OUT_W-1:0];
          if (hi_idx >= lo_idx) res.occ = OCC_W'(hi_idx - lo_idx + 1);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (mismatches < 40)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                          input bit sync = 1'b0);
    command_queue.push_back('{cmd, value, sync});
    queued_items++;
  endtask

  task automatic add_run(input int n_appends, input bit unsorted, input int n_queries);
    logic signed [31:0] vals[$];
    longint             v;
    logic [VALUE_W-1:0] key;
    int                 r;
    r = $urandom_range(0, 9);
    if (n_appends > DEPTH) v = -64'sd2147483648;
    else if (r == 0) v = -64'sd2147483648;
    else if (r == 1) v = 2147483647 - $urandom_range(0, 40);
    else v = longint'($signed($urandom));
    for (int i = 0; i < n_appends; i++) begin
      if (unsorted) begin
        key = 32'(v + $urandom_range(0, 7));
      end else begin
        if (i > 0) begin
          r = $urandom_range(0, 99);
          if (r < 40) v = v;
          else if (r < 85) v = v + $urandom_range(1, 4);
          else v = v + $urandom_range(1, 1 << 20);
          if (v > 2147483647) v = 2147483647;
        end
        key = 32'(v);
      end
      vals.push_back(key);
      add_item(CMD_APPEND, key);
    end
    for (int q = 0; q < n_queries; q++) begin
      r = $urandom_range(0, 9);
      if (vals.size() > 0 && r < 6) key = vals[$urandom_range(0, vals.size() - 1)];
      else if (vals.size() > 0 && r < 8)
        key = vals[$urandom_range(0, vals.size() - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      else if (r == 8) key = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      else key = $urandom;
      add_item(CMD_QUERY, key);
      if ($urandom_range(0, 11) == 0) add_item(CMD_UNUSED, $urandom);
      if ($urandom_range(0, 14) == 0) add_item(CMD_APPEND, $urandom);
    end
  endtask

  // drive input items
  always @(negedge clk) begin
    command_t item;
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap--;
        end else if (command_queue.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (command_queue[0].sync && expected_counts.size() != 0) begin
          in_tvalid <= 1'b0;
        end else begin
          item = command_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= item.cmd;
          in_tdata  <= item.value;
          send_gap  = pick_gap(send_quiet);
        end
      end
    end
  end

  // stall the result channel
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_stall > 0) begin
        out_tready <= 1'b0;
        recv_stall--;
      end else begin
        out_tready <= 1'b1;
        recv_stall = ($urandom_range(0, 3) == 0) ? pick_gap(recv_quiet) : 0;
      end
    end
  end

  // check results, then predict for the item taken at this edge
  always @(posedge clk) begin
    count_result_t got, want;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = expected_counts.pop_front();
          got  = out_tdata[RES_W-1:0];
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.occ !== want.occ) report_mismatch("occurrences", got.occ, want.occ);
          if (got.first !== want.first) report_mismatch("first_index", got.first, want.first);
          if (got.last !== want.last) report_mismatch("last_index", got.last, want.last);
          if (got.ovf !== want.ovf) report_mismatch("overflow", got.ovf, want.ovf);
          if (out_tdata[OUT_TDATA_W-1:RES_W] !== '0)
            report_mismatch("padding", out_tdata[OUT_TDATA_W-1:RES_W], 0);
        end
      end
      if (in_tvalid && in_tready) expected_counts.push_back(apply_command(in_tuser, in_tdata));
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int  budget;
    int  fill_size;
    bit  filled;
    bit  first_sync;

    // directed: empty store, signed extremes, duplicates, unused command, unsorted data
    add_item(CMD_CLEAR,  32'h0000_0000);
    add_item(CMD_QUERY,  32'h0000_0000);
    add_item(CMD_UNUSED, 32'hffff_ffff);
    add_item(CMD_APPEND, 32'h8000_0000);
    add_item(CMD_APPEND, 32'hffff_ffff);
    add_item(CMD_APPEND, 32'h0000_0000);
    add_item(CMD_APPEND, 32'h0000_0000);
    add_item(CMD_APPEND, 32'h0000_0000);
    add_item(CMD_APPEND, 32'h0000_0001);
    add_item(CMD_APPEND, 32'h7fff_ffff);
    add_item(CMD_QUERY,  32'h8000_0000);
    add_item(CMD_QUERY,  32'h7fff_ffff);
    add_item(CMD_QUERY,  32'h0000_0000);
    add_item(CMD_QUERY,  32'hffff_ffff);
    add_item(CMD_QUERY,  32'h0000_0005);
    add_item(CMD_QUERY,  32'h7fff_fffe);
    add_item(CMD_CLEAR,  32'hffff_ffff);
    add_item(CMD_APPEND, 32'd9);
    add_item(CMD_APPEND, 32'd2);
    add_item(CMD_APPEND, 32'd9);
    add_item(CMD_APPEND, 32'd2);
    add_item(CMD_QUERY,  32'd9);
    add_item(CMD_QUERY,  32'd2);
    add_item(CMD_QUERY,  32'd3);

    budget     = queued_items + RANDOM_ITEMS;
    filled     = 1'b0;
    first_sync = 1'b1;
    while (queued_items < budget) begin
      if (!filled && queued_items > budget / 2) begin
        // fill the store past its depth, then query the full store
        fill_size = queued_items;
        add_item(CMD_CLEAR, $urandom, 1'b1);
        add_run(DEPTH + 3, 1'b0, 20);
        add_item(CMD_CLEAR, $urandom, 1'b1);
        budget += queued_items - fill_size;
        filled = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        add_item(CMD_CLEAR, $urandom, first_sync);
        first_sync = 1'b0;
      end
      add_run(($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 120),
              $urandom_range(0, 6) == 0, $urandom_range(1, 8));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (command_queue.size() != 0 || in_tvalid || expected_counts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sokc_pkg.sv
sv/sorted_key_occurrence_count_top.sv
sv/sokc_checker.sv
sim/sorted_key_occurrence_count_top_tb.sv
